### rtl/dual_reload_countdown_timer_top_assert.svh
// ---------------------------------------------------------------------------
// Dual reload countdown timer - assertion macros
// Shorthand for the concurrent checks on the timer's ports.
// ---------------------------------------------------------------------------
`ifndef DUAL_RELOAD_COUNTDOWN_TIMER_TOP_ASSERT_SVH
`define DUAL_RELOAD_COUNTDOWN_TIMER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DRCT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DRCT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Check on the cycle after reset is held.
`define DRCT_ASSERT_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

### rtl/drct_pkg.sv
// ---------------------------------------------------------------------------
// Dual reload countdown timer - package
// Widths, codes and word types shared by the timer modules.
// ---------------------------------------------------------------------------
package drct_pkg;

   localparam int MAX_TIMERS          = 2;
   localparam int TIMER_COUNT_DEFAULT = 2;

   localparam int DATA_W  = 32;
   localparam int ADDR_W  = 4;
   localparam int OP_W    = 2;
   localparam int IRQ_W   = 2;
   localparam int CTRL_W  = 8;
   localparam int PRESC_W = 7;
   localparam int EXP_W   = 3;

   // Opcodes
   localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

   // Global register words
   localparam logic [ADDR_W-1:0] ADDR_ENABLE = 4'd0;
   localparam logic [ADDR_W-1:0] ADDR_STATUS = 4'd1;

   // Word offsets inside a timer's page
   localparam logic [1:0] SUB_CTRL     = 2'd0;
   localparam logic [1:0] SUB_INTERVAL = 2'd1;
   localparam logic [1:0] SUB_CURRENT  = 2'd2;

   // Control word bits
   localparam int CTRL_ENABLE_BIT   = 0;
   localparam int CTRL_RELOAD_BIT   = 1;
   localparam int CTRL_FAST_BIT     = 2;
   localparam int CTRL_PRESCALE_LSB = 4;
   localparam int CTRL_SINGLE_BIT   = 7;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [ADDR_W-1:0] word_address;
      logic [DATA_W-1:0] write_data;
      logic              tick_slow;
      logic              tick_fast;
   } req_payload_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic [IRQ_W-1:0]  irq_lines;
   } rsp_payload_type;

   // Decoded command seen by the lanes and the merge stage
   typedef struct packed {
      logic              tick;
      logic              read;
      logic              write;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] wdata;
      logic              slow;
      logic              fast;
   } cmd_type;

   // What one timer lane shows to the merge stage
   typedef struct packed {
      logic [CTRL_W-1:0] ctrl;
      logic [DATA_W-1:0] interval;
      logic [DATA_W-1:0] current;
      logic              expire;
   } lane_view_type;

endpackage

### rtl/drct_stream_if.sv
// ---------------------------------------------------------------------------
// Dual reload countdown timer - stream channel
// Valid/ready channel carrying one word of the given payload type.
// ---------------------------------------------------------------------------
interface drct_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/drct_lane.sv
// ---------------------------------------------------------------------------
// Dual reload countdown timer - timer lane
// One countdown timer: control, interval, current value and prescaler.
// ---------------------------------------------------------------------------
module drct_lane #(
   parameter int LANE_INDEX = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  drct_pkg::cmd_type       cmd,
   output drct_pkg::lane_view_type view
);

   localparam logic [1:0] LANE_PAGE = 2'(LANE_INDEX + 1);

   logic [drct_pkg::CTRL_W-1:0]  ctrl_ff, ctrl_in;
   logic [drct_pkg::DATA_W-1:0]  interval_ff, interval_in;
   logic [drct_pkg::DATA_W-1:0]  current_ff, current_in;
   logic [drct_pkg::PRESC_W-1:0] presc_ff, presc_in;

   logic                         sel;
   logic                         strobe;
   logic [drct_pkg::PRESC_W:0]   presc_next;
   logic [drct_pkg::PRESC_W:0]   divisor;
   logic                         fire;
   logic                         expire;

   assign sel        = (cmd.addr[3:2] == LANE_PAGE);
   assign strobe     = ctrl_ff[drct_pkg::CTRL_FAST_BIT] ? cmd.fast : cmd.slow;
   assign presc_next = {1'b0, presc_ff} + 8'd1;
   assign divisor    = 8'd1 << ctrl_ff[drct_pkg::CTRL_PRESCALE_LSB +: drct_pkg::EXP_W];
   assign fire       = (presc_next >= divisor);

   always_comb begin
      ctrl_in     = ctrl_ff;
      interval_in = interval_ff;
      current_in  = current_ff;
      presc_in    = presc_ff;
      expire      = 1'b0;

      // divided tick: count down, or expire and reload / stop
      if (accept && cmd.tick && ctrl_ff[drct_pkg::CTRL_ENABLE_BIT] && strobe) begin
         if (!fire) begin
            presc_in = presc_next[drct_pkg::PRESC_W-1:0];
         end else begin
            presc_in = '0;
            if (current_ff > 32'd1) begin
               current_in = current_ff - 32'd1;
            end else begin
               expire = 1'b1;
               if (ctrl_ff[drct_pkg::CTRL_SINGLE_BIT]) begin
                  current_in                          = '0;
                  ctrl_in[drct_pkg::CTRL_ENABLE_BIT] = 1'b0;
               end else begin
                  current_in = interval_ff;
               end
            end
         end
      end

      if (accept && cmd.write && sel) begin
         case (cmd.addr[1:0])
            drct_pkg::SUB_CTRL: begin
               ctrl_in                           = cmd.wdata[drct_pkg::CTRL_W-1:0];
               ctrl_in[drct_pkg::CTRL_RELOAD_BIT] = 1'b0;
               if (cmd.wdata[drct_pkg::CTRL_RELOAD_BIT]) begin
                  current_in = interval_ff;
                  presc_in   = '0;
               end
            end
            drct_pkg::SUB_INTERVAL: interval_in = cmd.wdata;
            drct_pkg::SUB_CURRENT:  current_in  = cmd.wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff     <= '0;
         interval_ff <= '0;
         current_ff  <= '0;
         presc_ff    <= '0;
      end else begin
         ctrl_ff     <= ctrl_in;
         interval_ff <= interval_in;
         current_ff  <= current_in;
         presc_ff    <= presc_in;
      end
   end

   assign view.ctrl     = ctrl_ff;
   assign view.interval = interval_ff;
   assign view.current  = current_ff;
   assign view.expire   = expire;

endmodule

### rtl/drct_merge.sv
// ---------------------------------------------------------------------------
// Dual reload countdown timer - merge stage
// Interrupt enable and status words, read mux and the result word.
// ---------------------------------------------------------------------------
module drct_merge #(
   parameter int TIMER_COUNT = drct_pkg::TIMER_COUNT_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  drct_pkg::cmd_type         cmd,
   input  drct_pkg::lane_view_type   lane_view [TIMER_COUNT],
   output drct_pkg::rsp_payload_type result
);

   logic [TIMER_COUNT-1:0]      enable_ff, enable_in;
   logic [TIMER_COUNT-1:0]      pending_ff, pending_in;
   logic [TIMER_COUNT-1:0]      expire_vec;
   logic                        wr_enable;
   logic                        wr_status;
   logic [drct_pkg::DATA_W-1:0] rd_word;

   assign wr_enable = accept && cmd.write && (cmd.addr == drct_pkg::ADDR_ENABLE);
   assign wr_status = accept && cmd.write && (cmd.addr == drct_pkg::ADDR_STATUS);

   always_comb begin
      for (int t = 0; t < TIMER_COUNT; t++) begin
         expire_vec[t] = lane_view[t].expire;
      end
   end

   // status is write-one-to-clear; expiries set it
   assign enable_in  = wr_enable ? cmd.wdata[TIMER_COUNT-1:0] : enable_ff;
   assign pending_in = (wr_status ? (pending_ff & ~cmd.wdata[TIMER_COUNT-1:0]) : pending_ff)
                       | expire_vec;

   always_comb begin
      rd_word = '0;
      if (cmd.read) begin
         if (cmd.addr == drct_pkg::ADDR_ENABLE) begin
            rd_word = drct_pkg::DATA_W'(enable_ff);
         end else if (cmd.addr == drct_pkg::ADDR_STATUS) begin
            rd_word = drct_pkg::DATA_W'(pending_ff);
         end else begin
            for (int t = 0; t < TIMER_COUNT; t++) begin
               if (cmd.addr[3:2] == 2'(t + 1)) begin
                  case (cmd.addr[1:0])
                     drct_pkg::SUB_CTRL:
                        rd_word = drct_pkg::DATA_W'(lane_view[t].ctrl);
                     drct_pkg::SUB_INTERVAL: rd_word = lane_view[t].interval;
                     drct_pkg::SUB_CURRENT:  rd_word = lane_view[t].current;
                     default:                rd_word = '0;
                  endcase
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= '0;
         pending_ff <= '0;
      end else begin
         enable_ff  <= enable_in;
         pending_ff <= pending_in;
      end
   end

   assign result.read_data = rd_word;
   assign result.irq_lines = drct_pkg::IRQ_W'(pending_in & enable_in);

endmodule

### rtl/dual_reload_countdown_timer_top.sv
// ---------------------------------------------------------------------------
// Dual reload countdown timer - top level
// Each request word is a clock tick, a register read or a register write for
// a bank of countdown timers; every request gives exactly one response word
// with the read data (zero unless a read) and the interrupt lines as they
// stand after that request. A request is taken every clock while the skid
// word is free: the timer lanes update in the cycle of acceptance and the
// response appears on the next cycle unless the output word is stalled. The
// response side holds an output word plus one skid word, so a stalled
// consumer costs one further accepted request before the request side drops
// ready; the lane update and the read mux set the one-word-per-clock rate.
// ---------------------------------------------------------------------------
module dual_reload_countdown_timer_top #(
   parameter int TIMER_COUNT = drct_pkg::TIMER_COUNT_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   drct_stream_if.sink   req_chan,
   drct_stream_if.source rsp_chan
);

   drct_pkg::cmd_type         cmd;
   drct_pkg::lane_view_type   lane_view [TIMER_COUNT];
   drct_pkg::rsp_payload_type result;

   drct_pkg::rsp_payload_type out_data_ff, out_data_in;
   drct_pkg::rsp_payload_type skid_data_ff, skid_data_in;
   logic                      out_valid_ff, out_valid_in;
   logic                      skid_valid_ff, skid_valid_in;

   logic                      req_ready;
   logic                      accept;
   logic                      pop;

   // Decode the opcode; an unknown code does nothing and reads zero
   always_comb begin
      cmd.tick  = 1'b0;
      cmd.read  = 1'b0;
      cmd.write = 1'b0;
      cmd.addr  = req_chan.payload.word_address;
      cmd.wdata = req_chan.payload.write_data;
      cmd.slow  = req_chan.payload.tick_slow;
      cmd.fast  = req_chan.payload.tick_fast;
      unique case (req_chan.payload.opcode)
         drct_pkg::OP_TICK:  cmd.tick  = 1'b1;
         drct_pkg::OP_READ:  cmd.read  = 1'b1;
         drct_pkg::OP_WRITE: cmd.write = 1'b1;
         default: ;
      endcase
   end

   // Take a word whenever the skid slot is free
   assign req_ready      = !skid_valid_ff;
   assign req_chan.ready = req_ready;
   assign accept         = req_chan.valid && req_ready;
   assign pop            = out_valid_ff && rsp_chan.ready;

   // One lane per timer, all updated in the cycle of acceptance
   for (genvar t = 0; t < TIMER_COUNT; t++) begin : g_lane
      drct_lane #(
         .LANE_INDEX (t)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .accept (accept),
         .cmd    (cmd),
         .view   (lane_view[t])
      );
   end

   // Combine lane expiries into status, build the response word
   drct_merge #(
      .TIMER_COUNT (TIMER_COUNT)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .cmd       (cmd),
      .lane_view (lane_view),
      .result    (result)
   );

   // Output word plus skid word: advance the skid word first, else the new result
   always_comb begin
      out_data_in   = out_data_ff;
      out_valid_in  = out_valid_ff;
      skid_data_in  = skid_data_ff;
      skid_valid_in = skid_valid_ff;
      if (pop || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_data_in  = result;
            out_valid_in = accept;
         end
      end else if (accept) begin
         // hold the output word, park the new result
         skid_data_in  = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_data_ff;

endmodule

### rtl/drct_checker.sv
// ---------------------------------------------------------------------------
// Dual reload countdown timer - port checker
// Concurrent checks on the timer's ports, bound to the top level.
// ---------------------------------------------------------------------------
`include "dual_reload_countdown_timer_top_assert.svh"

module drct_checker #(
   parameter int TIMER_COUNT = drct_pkg::TIMER_COUNT_DEFAULT
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input drct_pkg::rsp_payload_type rsp_payload
);

   // no response straight out of reset
   `DRCT_ASSERT_RESET(a_idle_after_reset, !rsp_valid, "response valid after reset")

   // an accepted word always leaves a response waiting on the next cycle
   `DRCT_ASSERT_NEXT(a_result_follows, req_valid && req_ready, rsp_valid, "accepted word lost")

   // back-pressure only while a response is pending
   `DRCT_ASSERT_NOW(a_stall_has_cause, !req_ready, rsp_valid, "ready low with no response")

   // a stalled response holds
   `DRCT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "response changed while stalled")

   // no interrupt line for a timer that does not exist
   `DRCT_ASSERT_NOW(a_irq_range, rsp_valid, (rsp_payload.irq_lines >> TIMER_COUNT) == '0, "interrupt on absent timer")

endmodule

bind dual_reload_countdown_timer_top drct_checker #(
   .TIMER_COUNT (TIMER_COUNT)
) u_drct_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

### sim/drct_checker.sv
// ---------------------------------------------------------------------------
// Dual reload countdown timer - response checker
// Watches both channels, predicts every response word from its own copy of
// the timer bank and compares it field by field with what the block returns.
// ---------------------------------------------------------------------------
module drct_tb_checker
   import drct_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_payload,
   output int              fail_count,
   output int              pending_words,
   output int              expiry_count
);

   localparam int               BANK_TIMERS = TIMER_COUNT_DEFAULT;
   localparam logic [IRQ_W-1:0] TIMER_MASK  = IRQ_W'((1 << BANK_TIMERS) - 1);
   localparam int               PRINT_CAP   = 50;

   // Shadow of the timer bank
   logic [IRQ_W-1:0]   irq_enable_m;
   logic [IRQ_W-1:0]   irq_status_m;
   logic [CTRL_W-1:0]  ctrl_m     [BANK_TIMERS];
   logic [DATA_W-1:0]  interval_m [BANK_TIMERS];
   logic [DATA_W-1:0]  count_m    [BANK_TIMERS];
   logic [PRESC_W-1:0] divider_m  [BANK_TIMERS];

   rsp_payload_type due_words[$];
   int              mismatches;
   int              expiries;
   int              rsp_index;

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                  input logic [DATA_W-1:0] got);
      if (mismatches < PRINT_CAP)
         $display("[%0t] mismatch on response %0d, %s: expected 0x%0h, got 0x%0h",
                  $time, rsp_index, what, want, got);
      mismatches++;
   endtask

   function automatic void step_timer(input int t, input logic slow, input logic fast);
      logic        strobe;
      int unsigned span;
      int unsigned next_div;
      if (!ctrl_m[t][CTRL_ENABLE_BIT])
         return;
      strobe = ctrl_m[t][CTRL_FAST_BIT] ? fast : slow;
      if (!strobe)
         return;
      span     = 1 << ctrl_m[t][CTRL_PRESCALE_LSB +: EXP_W];
      next_div = divider_m[t] + 1;
      if (next_div < span) begin
         divider_m[t] = next_div[PRESC_W-1:0];
         return;
      end
      divider_m[t] = '0;
      if (count_m[t] > 1) begin
         count_m[t] = count_m[t] - 1;
         return;
      end
      // reaching one or zero expires the timer
      irq_status_m[t] = 1'b1;
      expiries++;
      if (ctrl_m[t][CTRL_SINGLE_BIT]) begin
         count_m[t]                  = '0;
         ctrl_m[t][CTRL_ENABLE_BIT] = 1'b0;
      end else begin
         count_m[t] = interval_m[t];
      end
   endfunction

   function automatic logic [DATA_W-1:0] read_word(input logic [ADDR_W-1:0] a);
      int t;
      t = int'(a[ADDR_W-1:2]) - 1;
      if (t < 0) begin
         if (a == ADDR_ENABLE) return DATA_W'(irq_enable_m);
         if (a == ADDR_STATUS) return DATA_W'(irq_status_m);
         return '0;
      end
      if (t >= BANK_TIMERS)
         return '0;
      case (a[1:0])
         SUB_CTRL:     return DATA_W'(ctrl_m[t]);
         SUB_INTERVAL: return interval_m[t];
         SUB_CURRENT:  return count_m[t];
         default:      return '0;
      endcase
   endfunction

   function automatic void write_word(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
      int t;
      t = int'(a[ADDR_W-1:2]) - 1;
      if (t < 0) begin
         if (a == ADDR_ENABLE)
            irq_enable_m = d[IRQ_W-1:0] & TIMER_MASK;
         else if (a == ADDR_STATUS)
            irq_status_m = irq_status_m & ~d[IRQ_W-1:0] & TIMER_MASK;
      end else if (t < BANK_TIMERS) begin
         case (a[1:0])
            SUB_CTRL: begin
               ctrl_m[t]                  = d[CTRL_W-1:0];
               ctrl_m[t][CTRL_RELOAD_BIT] = 1'b0;
               if (d[CTRL_RELOAD_BIT]) begin
                  count_m[t]   = interval_m[t];
                  divider_m[t] = '0;
               end
            end
            SUB_INTERVAL: interval_m[t] = d;
            SUB_CURRENT:  count_m[t]    = d;
            default: ;
         endcase
      end
   endfunction

   function automatic rsp_payload_type apply_word(input req_payload_type w);
      rsp_payload_type r;
      r.read_data = '0;
      case (w.opcode)
         OP_TICK: begin
            for (int t = 0; t < BANK_TIMERS; t++)
               step_timer(t, w.tick_slow, w.tick_fast);
         end
         OP_READ:  r.read_data = read_word(w.word_address);
         OP_WRITE: write_word(w.word_address, w.write_data);
         default: ;
      endcase
      r.irq_lines = irq_status_m & irq_enable_m;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rsp_payload_type want;
      if (reset) begin
         irq_enable_m = '0;
         irq_status_m = '0;
         for (int t = 0; t < BANK_TIMERS; t++) begin
            ctrl_m[t]     = '0;
            interval_m[t] = '0;
            count_m[t]    = '0;
            divider_m[t]  = '0;
         end
         due_words.delete();
         mismatches = 0;
         expiries   = 0;
         rsp_index  = 0;
      end else begin
         // a response always belongs to an earlier request, so retire it first
         if (rsp_valid && rsp_ready) begin
            if (due_words.size() == 0) begin
               report_mismatch("response with nothing due", '0, rsp_payload.read_data);
            end else begin
               want = due_words.pop_front();
               if (want.read_data !== rsp_payload.read_data)
                  report_mismatch("read_data", want.read_data, rsp_payload.read_data);
               if (want.irq_lines !== rsp_payload.irq_lines)
                  report_mismatch("irq_lines", want.irq_lines, rsp_payload.irq_lines);
            end
            rsp_index++;
         end
         if (req_valid && req_ready)
            due_words.push_back(apply_word(req_payload));
      end
      fail_count    <= mismatches;
      pending_words <= due_words.size();
      expiry_count  <= expiries;
   end

endmodule

### sim/tb.sv
// ---------------------------------------------------------------------------
// Dual reload countdown timer - testbench top
// Drives tick, read and write words into the timer bank under four pacing
// phases and leaves prediction and comparison to the checker beside it.
// ---------------------------------------------------------------------------
module tb;
   import drct_pkg::*;

   localparam int               BANK_TIMERS  = TIMER_COUNT_DEFAULT;
   localparam logic [OP_W-1:0]  OP_SPARE     = 2'd3;   // opcode with no function
   localparam logic [1:0]       SUB_SPARE    = 2'd3;   // fourth word of a timer page
   localparam int               RANDOM_WORDS = 1050;
   localparam int               CYCLE_LIMIT  = 200000;
   localparam int               DRAIN_CYCLES = 8;

   // Pacing plan: none, sender idle, receiver stalling, both
   int idle_plan  [4] = '{0, 47, 0, 17};
   int stall_plan [4] = '{0, 0, 47, 17};

   bit   clock;
   logic reset;
   int   idle_pct;
   int   stall_pct;
   int   cycle_count;
   int   words_sent;
   int   ticks_sent;
   int   reads_sent;
   int   writes_sent;
   int   spares_sent;
   int   fail_count;
   int   pending_words;
   int   expiry_count;

   drct_stream_if #(.payload_type(req_payload_type)) req_chan ();
   drct_stream_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   dual_reload_countdown_timer_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   drct_tb_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .req_payload   (req_chan.payload),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_payload   (rsp_chan.payload),
      .fail_count    (fail_count),
      .pending_words (pending_words),
      .expiry_count  (expiry_count)
   );

   always #2 clock = ~clock;

   // Stall the response side at random; change only on the falling edge
   always @(negedge clock) begin
      rsp_chan.ready = ($urandom_range(99) >= stall_pct);
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still due", cycle_count, pending_words);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Word address of a register in timer t's page (pages start after the global one)
   function automatic logic [ADDR_W-1:0] timer_word(input int t, input logic [1:0] sub);
      return ADDR_W'(((t + 1) << 2) | sub);
   endfunction

   // Overlay the named control fields on a random base, keeping the spare bits random
   function automatic logic [DATA_W-1:0] ctrl_data(input logic [DATA_W-1:0] base,
                                                   input logic en, input logic rl,
                                                   input logic fs, input logic [EXP_W-1:0] ps,
                                                   input logic sg);
      logic [DATA_W-1:0] d;
      d = base;
      d[CTRL_ENABLE_BIT]                = en;
      d[CTRL_RELOAD_BIT]                = rl;
      d[CTRL_FAST_BIT]                  = fs;
      d[CTRL_PRESCALE_LSB +: EXP_W]     = ps;
      d[CTRL_SINGLE_BIT]                = sg;
      return d;
   endfunction

   // Present one word at the falling edge and hold it until the block takes it
   task automatic drive_word(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data, input logic slow,
                             input logic fast);
      req_payload_type w;
      w.opcode       = op;
      w.word_address = addr;
      w.write_data   = data;
      w.tick_slow    = slow;
      w.tick_fast    = fast;
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid   = 1'b1;
      req_chan.payload = w;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      words_sent++;
      case (op)
         OP_TICK:  ticks_sent++;
         OP_READ:  reads_sent++;
         OP_WRITE: writes_sent++;
         default:  spares_sent++;
      endcase
   endtask

   // Fields a word ignores are filled at random
   task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
      drive_word(OP_WRITE, addr, data, 1'($urandom), 1'($urandom));
   endtask

   task automatic read_reg(input logic [ADDR_W-1:0] addr);
      drive_word(OP_READ, addr, $urandom, 1'($urandom), 1'($urandom));
   endtask

   task automatic tick(input logic slow, input logic fast);
      drive_word(OP_TICK, ADDR_W'($urandom), $urandom, slow, fast);
   endtask

   // Mostly well-formed timer set-ups followed by tick bursts, with some noise
   task automatic run_random(input int goal);
      int                t;
      int                ps;
      logic [DATA_W-1:0] span;
      while (words_sent < goal) begin
         if ($urandom_range(9) < 2) begin
            // noise: any opcode, any address, any data
            repeat ($urandom_range(1, 4))
               drive_word(OP_W'($urandom), ADDR_W'($urandom), $urandom,
                          1'($urandom), 1'($urandom));
         end else begin
            t    = $urandom_range(BANK_TIMERS - 1);
            span = ($urandom_range(9) < 8) ? DATA_W'($urandom_range(6)) : $urandom;
            write_reg(timer_word(t, SUB_INTERVAL), span);
            if ($urandom_range(9) < 3)
               write_reg(timer_word(t, SUB_CURRENT),
                         $urandom_range(1) ? DATA_W'($urandom_range(4)) : $urandom);
            if ($urandom_range(1))
               write_reg(ADDR_ENABLE, $urandom);
            // keep the divider short most of the time so expiries come often
            ps = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(2);
            write_reg(timer_word(t, SUB_CTRL),
                      ctrl_data($urandom, $urandom_range(9) != 0, $urandom_range(9) < 7,
                                1'($urandom_range(1)), EXP_W'(ps), 1'($urandom_range(1))));
            repeat ($urandom_range(4, 24)) begin
               case ($urandom_range(19))
                  0, 1:    read_reg(ADDR_W'($urandom));
                  2:       write_reg(ADDR_STATUS, $urandom);
                  default: tick(1'($urandom_range(1)), 1'($urandom_range(1)));
               endcase
            end
            read_reg(ADDR_STATUS);
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      idle_pct         = 0;
      stall_pct        = 0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // Directed part: reset values, extremes, expiry in both modes, W1C status
      read_reg(ADDR_ENABLE);
      read_reg(timer_word(1, SUB_CURRENT));
      write_reg(ADDR_ENABLE, '1);                       // bits above the timers drop
      write_reg(timer_word(0, SUB_INTERVAL), '1);
      write_reg(timer_word(0, SUB_CTRL), '1);           // reload, fast, prescale 7, single
      read_reg(timer_word(0, SUB_CTRL));                // reload bit must read back clear
      read_reg(timer_word(0, SUB_CURRENT));
      write_reg(timer_word(1, SUB_INTERVAL), 2);
      write_reg(timer_word(1, SUB_CTRL), ctrl_data('0, 1'b1, 1'b1, 1'b1, '0, 1'b0));
      repeat (3) tick(1'b0, 1'b1);                      // count down through auto reload
      read_reg(ADDR_STATUS);
      write_reg(ADDR_STATUS, 32'hFFFF_FFFC);            // clears nothing
      write_reg(ADDR_STATUS, '1);
      write_reg(timer_word(1, SUB_CURRENT), '0);
      tick(1'b1, 1'b1);                                 // expiry straight from zero
      write_reg(timer_word(1, SUB_CURRENT), 1);
      write_reg(timer_word(1, SUB_CTRL), ctrl_data('0, 1'b1, 1'b0, 1'b1, '0, 1'b1));
      tick(1'b0, 1'b1);                                 // single mode drops enable
      read_reg(timer_word(1, SUB_CTRL));
      // lower the prescale under a running divider
      write_reg(timer_word(0, SUB_CTRL), ctrl_data('0, 1'b1, 1'b0, 1'b0, '0, 1'b0));
      tick(1'b1, 1'b0);
      drive_word(OP_SPARE, '1, '1, 1'b1, 1'b1);
      write_reg(timer_word(BANK_TIMERS, SUB_CTRL), '1); // page beyond the last timer
      read_reg(timer_word(BANK_TIMERS, SUB_SPARE));
      read_reg(timer_word(0, SUB_SPARE));

      // Random part, one slice per pacing phase
      for (int p = 0; p < 4; p++) begin
         idle_pct  = idle_plan[p];
         stall_pct = stall_plan[p];
         run_random(words_sent + RANDOM_WORDS / 4);
      end

      // Drop valid and let the response side drain
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending_words != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d words: %0d ticks, %0d reads, %0d writes, %0d with the spare opcode.",
               words_sent, ticks_sent, reads_sent, writes_sent, spares_sent);
      $display("Saw %0d timer expiries across four pacing phases; %0d mismatches.",
               expiry_count, fail_count);
      if (fail_count == 0 && pending_words == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### dual_reload_countdown_timer_top.f
+incdir+rtl
rtl/drct_pkg.sv
rtl/drct_stream_if.sv
rtl/drct_lane.sv
rtl/drct_merge.sv
rtl/dual_reload_countdown_timer_top.sv
rtl/drct_checker.sv
sim/drct_checker.sv
sim/tb.sv
